[rtl/spe_pkg.sv]
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants for the sysex packet encoder
// Item codes, the command record passed from front to back, and the
// CRC-16 CCITT byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  // Input item modes
  localparam logic [1:0] MODE_OPEN  = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  // Framing constants
  localparam int unsigned GROUP_SIZE  = 7;
  localparam int unsigned GCNT_W      = 3;
  localparam int unsigned STEP_W      = 4;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [6:0]  SYNC_MARKER = 7'h01;
  localparam logic [15:0] LEN_BIAS    = 16'd4;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic        last_pkt;     // close with next length zero: pad the group
    logic [7:0]  data_byte;
    logic [15:0] type_word;
    logic [15:0] word;         // open: length + 4; close: next length + 4, or zero
  } cmd_t;

  // CRC-16 CCITT, polynomial 0x1021, one byte per call
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [7:0]  t;
    logic [15:0] q;
    logic [15:0] r;
    t = crc[15:8] ^ b;
    q = {8'h00, t ^ (t >> 4)};
    r = {crc[7:0], 8'h00};
    r = r ^ q ^ (q << 5) ^ (q << 12);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/spe_fifo.sv]
// ----------------------------------------------------------------------------
// spe_fifo: small first-in first-out queue
// Register-based queue with separate push and pop sides; full and empty
// depend only on the stored count.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/spe_front.sv]
// ----------------------------------------------------------------------------
// spe_front: item classifier
// Takes input items, drops unused modes, and builds the command record
// with the biased length words precomputed.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_front
  import spe_pkg::*;
(
  input  wire         push_i,
  input  wire  [1:0]  mode_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [15:0] type_word_i,
  input  wire  [15:0] data_length_i,
  input  wire         cmd_full_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  logic        accept;
  logic        len_zero;
  logic [15:0] len_biased;

  assign accept     = push_i && !cmd_full_i;
  assign len_zero   = (data_length_i == '0);
  assign len_biased = data_length_i + LEN_BIAS;

  // Classify the item; an unused mode is accepted and dropped
  always_comb begin
    cmd_push_o      = 1'b0;
    cmd_o.kind      = KIND_DATA;
    cmd_o.last_pkt  = 1'b0;
    cmd_o.data_byte = data_byte_i;
    cmd_o.type_word = type_word_i;
    cmd_o.word      = len_biased;
    case (mode_i)
      MODE_OPEN: begin
        cmd_push_o = accept;
        cmd_o.kind = KIND_OPEN;
      end
      MODE_DATA: begin
        cmd_push_o = accept;
        cmd_o.kind = KIND_DATA;
      end
      MODE_CLOSE: begin
        cmd_push_o     = accept;
        cmd_o.kind     = KIND_CLOSE;
        cmd_o.last_pkt = len_zero;
        cmd_o.word     = len_zero ? '0 : len_biased;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/spe_engine.sv]
// ----------------------------------------------------------------------------
// spe_engine: byte sequencer
// Steps through each command one output byte per cycle while the result
// queue is not full, keeping the CRC, the gathered top bits and the group
// count, and inserting the top-bit byte after every full group.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_engine
  import spe_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  input  wire         cmd_empty_i,
  output logic        cmd_pop_o,
  input  wire         out_full_i,
  output logic        out_push_o,
  output logic [6:0]  out_byte_o,
  output logic        out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ENC  = 3'b010,
    ST_TOP  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [15:0]         crc_q, crc_d;
  logic [6:0]          gather_q, gather_d;
  logic [GCNT_W-1:0]   gcount_q, gcount_d;
  logic                top_end_q, top_end_d;

  logic [7:0]          enc_byte;
  logic                enc_crc;
  logic                enc_last;
  logic                close_final;
  logic                wrap;
  logic                finish;

  assign close_final = (cmd_q.kind == KIND_CLOSE) && cmd_q.last_pkt;
  assign wrap        = (gcount_q == GCNT_W'(GROUP_SIZE - 1));

  // Select the byte to encode at this step
  always_comb begin
    enc_byte = 8'h00;
    enc_crc  = 1'b0;
    enc_last = 1'b0;
    case (cmd_q.kind)
      KIND_OPEN: begin
        enc_crc  = (step_q <= STEP_W'(4));
        enc_last = (step_q == STEP_W'(6));
        case (step_q)
          STEP_W'(1): enc_byte = cmd_q.type_word[15:8];
          STEP_W'(2): enc_byte = cmd_q.type_word[7:0];
          STEP_W'(3): enc_byte = cmd_q.word[15:8];
          STEP_W'(4): enc_byte = cmd_q.word[7:0];
          STEP_W'(5): enc_byte = crc_q[15:8];
          STEP_W'(6): enc_byte = crc_q[7:0];
          default:    enc_byte = 8'h00;
        endcase
      end
      KIND_DATA: begin
        enc_crc  = 1'b1;
        enc_last = 1'b1;
        enc_byte = cmd_q.data_byte;
      end
      KIND_CLOSE: begin
        enc_crc  = (step_q <= STEP_W'(1));
        enc_last = (step_q >= STEP_W'(3));
        case (step_q)
          STEP_W'(0): enc_byte = cmd_q.word[15:8];
          STEP_W'(1): enc_byte = cmd_q.word[7:0];
          STEP_W'(2): enc_byte = crc_q[15:8];
          STEP_W'(3): enc_byte = crc_q[7:0];
          default:    enc_byte = 8'h00;
        endcase
      end
      default: begin
        enc_byte = 8'h00;
      end
    endcase
  end

  // Sequence output bytes
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    step_d     = step_q;
    crc_d      = crc_q;
    gather_d   = gather_q;
    gcount_d   = gcount_q;
    top_end_d  = top_end_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_byte_o = '0;
    out_last_o = 1'b0;
    finish     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          step_d    = '0;
          state_d   = ST_ENC;
        end
      end
      ST_ENC: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          step_d     = step_q + 1'b1;
          if ((cmd_q.kind == KIND_OPEN) && (step_q == '0)) begin
            // Raw marker restarts grouping and CRC
            out_byte_o = SYNC_MARKER;
            crc_d      = CRC_SEED;
            gather_d   = '0;
            gcount_d   = '0;
          end else begin
            out_byte_o = enc_byte[6:0];
            if (enc_crc) begin
              crc_d = crc16_update(crc_q, enc_byte);
            end
            gather_d = {enc_byte[7], gather_q[6:1]};
            gcount_d = wrap ? '0 : gcount_q + 1'b1;
            if (wrap) begin
              state_d   = ST_TOP;
              top_end_d = enc_last;
            end else if (enc_last && !close_final) begin
              out_last_o = 1'b1;
              finish     = 1'b1;
            end
          end
        end
      end
      ST_TOP: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          out_byte_o = gather_q;
          if (top_end_q) begin
            out_last_o = 1'b1;
            finish     = 1'b1;
          end else begin
            state_d = ST_ENC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Retire the command and pick up the next one without a bubble
    if (finish) begin
      if (cmd_q.kind != KIND_DATA) begin
        crc_d = CRC_SEED;
      end
      if (!cmd_empty_i) begin
        cmd_pop_o = 1'b1;
        cmd_d     = cmd_i;
        step_d    = '0;
        state_d   = ST_ENC;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      crc_q     <= CRC_SEED;
      gather_q  <= '0;
      gcount_q  <= '0;
      top_end_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      crc_q     <= crc_d;
      gather_q  <= gather_d;
      gcount_q  <= gcount_d;
      top_end_q <= top_end_d;
    end
  end

  // Hold the current command
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

`default_nettype wire

[rtl/sysex_packet_encoder_crc16.sv]
// ----------------------------------------------------------------------------
// sysex_packet_encoder_crc16: sysex packet framer with CRC-16
// Packs packet headers, payload bytes and CRCs into 7-bit sysex bytes,
// seven at a time with a trailing byte of top bits.
//
//   channel   handshake      payload
//   input     push / full    mode_i, data_byte_i, type_word_i, data_length_i
//   result    pop / empty    out_byte_o, last_of_run_o
//
// The back engine emits one byte per cycle while the result queue has room; a data
// item gives 1 or 2 bytes, an open item 7, a close item 4 to 12 (a final close pads
// out its group); an idle engine loads a new command before sending its bytes.
// A command queue of CMD_DEPTH items decouples input from the engine, and
// a result queue of OUT_DEPTH bytes decouples the engine from pop.
// Reset is asynchronous, active low; it empties both queues and sets the
// CRC to 0xFFFF with the group count and top bits at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sysex_packet_encoder_crc16
  import spe_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire  [1:0]  mode_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [15:0] type_word_i,
  input  wire  [15:0] data_length_i,
  output logic        empty,
  input  wire         pop,
  output logic [6:0]  out_byte_o,
  output logic        last_of_run_o
);

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned OUT_W = 8;

  logic             cmd_push, cmd_pop, cmd_empty;
  cmd_t             cmd_in, cmd_out;
  logic [CMD_W-1:0] cmd_out_bits;
  logic             out_push, out_full, out_last;
  logic [6:0]       out_byte;
  logic [OUT_W-1:0] out_bits;

  // Classify incoming items
  spe_front u_front (
    .push_i        (push),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .type_word_i   (type_word_i),
    .data_length_i (data_length_i),
    .cmd_full_i    (full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  // Queue commands between front and engine
  spe_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out_bits),
    .empty_o (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_out_bits);

  // Produce output bytes
  spe_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  // Buffer results toward the consumer
  spe_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({out_last, out_byte}),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_bits),
    .empty_o (empty)
  );

  assign out_byte_o    = out_bits[6:0];
  assign last_of_run_o = out_bits[7];

endmodule

`default_nettype wire
